>>> hdl/jvs_pkg.sv
`default_nettype none
package jvs_pkg;

	localparam int unsigned STACK_DEPTH = 32;
	localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	typedef struct packed {
		logic       format_error;
		logic       value_end;
		logic [7:0] kept_char;
		logic       has_char;
	} result_t;

	typedef struct packed {
		logic level_zero;
		logic str_open;
	} status_t;

endpackage
`default_nettype wire

>>> hdl/jvs_tracker.sv
`default_nettype none
module jvs_tracker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           in_char,
	input  wire logic                 in_last,
	input  wire logic                 commit,
	output jvs_pkg::result_t          res,
	output logic                      res_emit,
	output jvs_pkg::status_t          status
);

	logic [jvs_pkg::STACK_DEPTH-1:0] stack_q;
	logic [jvs_pkg::LVL_W-1:0]       level_q;
	logic [jvs_pkg::LVL_W-1:0]       braces_q;
	logic                            in_str_q;

	logic [jvs_pkg::LVL_W-1:0] level_d;
	logic [jvs_pkg::LVL_W-1:0] braces_d;
	logic                      in_str_d;
	logic                      do_push;
	logic                      is_brace;
	logic                      keep;
	logic                      vend;
	logic                      err;
	logic [jvs_pkg::LVL_W-1:0] level_m1;
	logic                      top_bit;
	logic                      full;

	assign level_m1 = level_q - jvs_pkg::LVL_W'(1);
	assign top_bit  = stack_q[level_m1[jvs_pkg::IDX_W-1:0]];
	assign full     = (level_q == jvs_pkg::LVL_W'(jvs_pkg::STACK_DEPTH));
	assign is_brace = (in_char == jvs_pkg::CH_LBRACE) || (in_char == jvs_pkg::CH_RBRACE);

	always_comb begin
		level_d  = level_q;
		braces_d = braces_q;
		in_str_d = in_str_q;
		do_push  = 1'b0;
		keep     = 1'b0;
		vend     = 1'b0;
		err      = 1'b0;
		if ((in_char == jvs_pkg::CH_CR) || (in_char == jvs_pkg::CH_LF)) begin
			keep = 1'b0;
		end else if (in_str_q) begin
			keep = 1'b1;
			if (in_char == jvs_pkg::CH_QUOTE) begin
				in_str_d = 1'b0;
			end
		end else if (in_char == jvs_pkg::CH_QUOTE) begin
			keep = 1'b1;
			if (level_q == '0) begin
				in_str_d = 1'b1;
			end
		end else if (in_char == jvs_pkg::CH_SPACE) begin
			keep = (braces_q != '0);
		end else if ((in_char == jvs_pkg::CH_COMMA) && (level_q == '0)) begin
			vend = 1'b1;
		end else if ((in_char == jvs_pkg::CH_LBRACK) || (in_char == jvs_pkg::CH_LBRACE)) begin
			keep = 1'b1;
			if (full) begin
				err = 1'b1;
			end else begin
				do_push = 1'b1;
				level_d = level_q + jvs_pkg::LVL_W'(1);
				if (is_brace) begin
					braces_d = braces_q + jvs_pkg::LVL_W'(1);
				end
			end
		end else if ((in_char == jvs_pkg::CH_RBRACK) || (in_char == jvs_pkg::CH_RBRACE)) begin
			keep = 1'b1;
			if ((level_q == '0) || (top_bit != is_brace)) begin
				err = 1'b1;
			end else begin
				level_d = level_m1;
				if (is_brace && (braces_q != '0)) begin
					braces_d = braces_q - jvs_pkg::LVL_W'(1);
				end
			end
		end else begin
			keep = 1'b1;
		end

		if (in_last) begin
			vend = 1'b1;
			if ((level_d != '0) || in_str_d) begin
				err = 1'b1;
			end
			level_d  = '0;
			braces_d = '0;
			in_str_d = 1'b0;
		end
	end

	assign res.has_char     = keep;
	assign res.kept_char    = keep ? in_char : 8'h00;
	assign res.value_end    = vend;
	assign res.format_error = err;
	assign res_emit         = keep | vend | err;

	assign status.level_zero = (level_q == '0);
	assign status.str_open   = in_str_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q  <= '0;
			level_q  <= '0;
			braces_q <= '0;
			in_str_q <= 1'b0;
		end else if (commit) begin
			level_q  <= level_d;
			braces_q <= braces_d;
			in_str_q <= in_str_d;
			if (do_push) begin
				stack_q[level_q[jvs_pkg::IDX_W-1:0]] <= is_brace;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/json_value_splitter.sv
// A word accepted at the input passes through the input register and then the result register to the output.
// Throughput: one word per cycle when the output side does not stall.
// Characters that give no result (dropped line breaks and spaces) leave no output word.
// Reset (arst_n low) clears the bracket stack, level, brace count and string flag
// and empties both the input and result registers.
`default_nettype none
module json_value_splitter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_char
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] kept_char
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser   // [0] has_char, [1] format_error
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             out_valid_q;
	jvs_pkg::result_t out_q;

	logic             out_free;
	logic             advance;
	jvs_pkg::result_t res;
	logic             res_emit;
	jvs_pkg::status_t status;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	jvs_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_char  (char_s1),
		.in_last  (last_s1),
		.commit   (advance),
		.res      (res),
		.res_emit (res_emit),
		.status   (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_emit) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.kept_char;
	assign m_axis_tlast  = out_q.value_end;
	assign m_axis_tuser  = {out_q.format_error, out_q.has_char};

	a_no_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast || m_axis_tuser[1]))
		else $error("output word carries no character and no flag");

	a_dropped_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
		else $error("kept_char nonzero without has_char");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (status.level_zero && !status.str_open))
		else $error("state not cleared after final character");

endmodule
`default_nettype wire
